// File: hw/rtl/cdda_pkg.sv
// Shared types, constants and calendar helpers for the calendar date day adder.
// No dependencies; imported by every module of the block.
package cdda_pkg;

    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned Y400_W  = 9;

    localparam logic [YEAR_W-1:0]  LAST_YEAR  = 14'd9999;
    localparam logic [YEAR_W-1:0]  FIRST_YEAR = 14'd1;
    localparam logic [YEAR_W-1:0]  CYCLE_LEN  = 14'd400;
    localparam logic [Y400_W-1:0]  CYCLE_LAST = 9'd399;
    localparam logic [MONTH_W-1:0] JANUARY    = 4'd1;
    localparam logic [MONTH_W-1:0] FEBRUARY   = 4'd2;
    localparam logic [MONTH_W-1:0] DECEMBER   = 4'd12;
    localparam logic [DAY_W-1:0]   FIRST_DAY  = 5'd1;
    localparam logic [DAY_W-1:0]   LAST_DAY   = 5'd31;

    // Outcome of one month step of the walk
    typedef struct packed {
        logic [DAY_W-1:0]   len;        // days in the current month
        logic               fits;       // remaining count ends inside this month
        logic [DAY_W-1:0]   day_sum;    // day after adding the remaining count
        logic [COUNT_W-1:0] left_next;  // count left after leaving this month
    } t_step;

    // Leap rule from the year's position in the 400-year cycle
    function automatic logic is_leap(input logic [Y400_W-1:0] y400);
        is_leap = (y400[1:0] == 2'd0) && (y400 != 9'd100) && (y400 != 9'd200)
                  && (y400 != 9'd300);
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                  month_len = 5'd30;
            4'd2:                                     month_len = leap ? 5'd29 : 5'd28;
            default:                                  month_len = 5'd31;
        endcase
    endfunction

endpackage

// File: hw/rtl/calendar_date_day_adder_unit.sv
// Top level of the calendar date day adder: sequencer, date state and output register.
// Depends on cdda_pkg and cdda_step.
//
// Keeps one Gregorian date (year 1..9999) and answers every input item with one result
// item holding the date after it. A load item (op 0) clamps the given year, month and day
// into range and stores them; it then passes through S_MOD, where repeated subtraction
// of 400 finds the year's place in the 400-year leap cycle, S_LOAD_FIN, where the day is
// clamped to the month length, and S_OUT. An add item (op 1) walks forward one month per
// cycle through the shared month step unit until the count ends inside a month, then
// goes to S_OUT. Walking past 9999-12-31 saturates there and raises year_overflow. The
// input side is stalled from acceptance until the result has been placed in the output
// register; that register lets the next item be accepted while the previous result still
// waits downstream.
module calendar_date_day_adder_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_op,
    input  logic [cdda_pkg::YEAR_W-1:0]  i_load_year,
    input  logic [cdda_pkg::MONTH_W-1:0] i_load_month,
    input  logic [cdda_pkg::DAY_W-1:0]   i_load_day,
    input  logic [cdda_pkg::COUNT_W-1:0] i_day_count,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [cdda_pkg::YEAR_W-1:0]  o_cur_year,
    output logic [cdda_pkg::MONTH_W-1:0] o_cur_month,
    output logic [cdda_pkg::DAY_W-1:0]   o_cur_day,
    output logic                         o_year_overflow
);
    import cdda_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_LOAD_FIN,
        S_WALK,
        S_OUT
    } t_state;

    t_state              r_state;
    logic [YEAR_W-1:0]   r_year;
    logic [MONTH_W-1:0]  r_month;
    logic [DAY_W-1:0]    r_day;
    logic [Y400_W-1:0]   r_y400;     // year modulo 400, tracked alongside r_year
    logic [YEAR_W-1:0]   r_rem;      // working remainder while loading
    logic [COUNT_W-1:0]  r_left;     // days still to add
    logic                r_ovf;
    logic                r_out_valid;
    logic [YEAR_W-1:0]   r_out_year;
    logic [MONTH_W-1:0]  r_out_month;
    logic [DAY_W-1:0]    r_out_day;
    logic                r_out_ovf;

    logic [YEAR_W-1:0]   n_year;
    logic [MONTH_W-1:0]  n_month;
    t_step               step;
    logic                in_take;
    logic                out_take;

    cdda_step u_step (
        .i_y400  (r_y400),
        .i_month (r_month),
        .i_day   (r_day),
        .i_left  (r_left),
        .o_step  (step)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_take    = i_in_valid && (r_state == S_IDLE);
    assign out_take   = r_out_valid && !i_out_stall;

    // Clamp the load fields into range
    always_comb begin
        if (i_load_year < FIRST_YEAR) begin
            n_year = FIRST_YEAR;
        end else if (i_load_year > LAST_YEAR) begin
            n_year = LAST_YEAR;
        end else begin
            n_year = i_load_year;
        end
        if (i_load_month < JANUARY) begin
            n_month = JANUARY;
        end else if (i_load_month > DECEMBER) begin
            n_month = DECEMBER;
        end else begin
            n_month = i_load_month;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_year      <= FIRST_YEAR;
            r_month     <= JANUARY;
            r_day       <= FIRST_DAY;
            r_y400      <= 9'd1;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the result once taken, unless a fresh one replaces it this cycle
            if (out_take && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_ovf <= 1'b0;
                        if (i_op) begin
                            r_left  <= i_day_count;
                            r_state <= S_WALK;
                        end else begin
                            r_year  <= n_year;
                            r_month <= n_month;
                            r_day   <= i_load_day;
                            r_rem   <= n_year;
                            r_state <= S_MOD;
                        end
                    end
                end
                S_MOD: begin
                    // reduce the year modulo 400 by repeated subtraction
                    if (r_rem >= CYCLE_LEN) begin
                        r_rem <= r_rem - CYCLE_LEN;
                    end else begin
                        r_y400  <= r_rem[Y400_W-1:0];
                        r_state <= S_LOAD_FIN;
                    end
                end
                S_LOAD_FIN: begin
                    // month length is known now: clamp the day
                    if (r_day < FIRST_DAY) begin
                        r_day <= FIRST_DAY;
                    end else if (r_day > step.len) begin
                        r_day <= step.len;
                    end
                    r_state <= S_OUT;
                end
                S_WALK: begin
                    if (step.fits) begin
                        r_day   <= step.day_sum;
                        r_state <= S_OUT;
                    end else begin
                        r_left <= step.left_next;
                        r_day  <= FIRST_DAY;
                        if (r_month >= DECEMBER) begin
                            if (r_year >= LAST_YEAR) begin
                                // saturate at the last representable day
                                r_year  <= LAST_YEAR;
                                r_month <= DECEMBER;
                                r_day   <= LAST_DAY;
                                r_ovf   <= 1'b1;
                                r_state <= S_OUT;
                            end else begin
                                r_year  <= r_year + 14'd1;
                                r_month <= JANUARY;
                                r_y400  <= (r_y400 == CYCLE_LAST) ? '0 : r_y400 + 9'd1;
                            end
                        end else begin
                            r_month <= r_month + 4'd1;
                        end
                    end
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (!r_out_valid || out_take) begin
                        r_out_valid <= 1'b1;
                        r_out_year  <= r_year;
                        r_out_month <= r_month;
                        r_out_day   <= r_day;
                        r_out_ovf   <= r_ovf;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_cur_year      = r_out_year;
    assign o_cur_month     = r_out_month;
    assign o_cur_day       = r_out_day;
    assign o_year_overflow = r_out_ovf;

endmodule

// File: hw/rtl/cdda_step.sv
// Month step unit of the calendar date day adder: month length and one walk step.
// Depends on cdda_pkg.
module cdda_step (
    input  logic [cdda_pkg::Y400_W-1:0]  i_y400,
    input  logic [cdda_pkg::MONTH_W-1:0] i_month,
    input  logic [cdda_pkg::DAY_W-1:0]   i_day,
    input  logic [cdda_pkg::COUNT_W-1:0] i_left,
    output cdda_pkg::t_step              o_step
);
    import cdda_pkg::*;

    logic [COUNT_W:0]   sum;
    logic [DAY_W-1:0]   len;
    logic [COUNT_W-1:0] used;

    always_comb begin
        len  = month_len(i_month, is_leap(i_y400));
        sum  = {{(COUNT_W+1-DAY_W){1'b0}}, i_day} + {1'b0, i_left};
        // days taken up to and including the first of the next month
        used = {{(COUNT_W-DAY_W){1'b0}}, len - i_day} + {{(COUNT_W-1){1'b0}}, 1'b1};
        o_step.len       = len;
        o_step.fits      = (sum <= {{(COUNT_W+1-DAY_W){1'b0}}, len});
        o_step.day_sum   = sum[DAY_W-1:0];
        o_step.left_next = i_left - used;
    end

endmodule

// File: hw/rtl/cdda_checker.sv
// Port-level checker for the calendar date day adder, with its bind to the top level.
// Depends on cdda_pkg and calendar_date_day_adder_unit.
module cdda_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic [cdda_pkg::YEAR_W-1:0]  o_cur_year,
    input logic [cdda_pkg::MONTH_W-1:0] o_cur_month,
    input logic [cdda_pkg::DAY_W-1:0]   o_cur_day,
    input logic                         o_year_overflow
);
    import cdda_pkg::*;

    // the input is stalled in the cycle after an item is accepted
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepting an item");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_cur_year)
        && $stable(o_cur_month) && $stable(o_cur_day) && $stable(o_year_overflow)))
        else $error("stalled result changed");

    a_ovf_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_year_overflow) |-> (o_cur_year == LAST_YEAR
        && o_cur_month == DECEMBER && o_cur_day == LAST_DAY))
        else $error("overflow without saturated date");

    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_cur_year >= FIRST_YEAR && o_cur_year <= LAST_YEAR
        && o_cur_month >= JANUARY && o_cur_month <= DECEMBER
        && o_cur_day >= FIRST_DAY && o_cur_day <= LAST_DAY))
        else $error("result date out of range");

endmodule

bind calendar_date_day_adder_unit cdda_checker u_cdda_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_cur_year      (o_cur_year),
    .o_cur_month     (o_cur_month),
    .o_cur_day       (o_cur_day),
    .o_year_overflow (o_year_overflow)
);

// File: tb/calendar_date_day_adder_checker.sv
`timescale 1ns / 1ps
// Checker for the calendar date day adder: watches both item channels, predicts every result
// date from its own copy of the stored date and compares it with what the block hands out.
// Depends on cdda_pkg; also holds cdda_tb_pkg, the operation codes shared with the bench top.

package cdda_tb_pkg;
    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_ADD  = 1'b1
    } t_date_op;
endpackage

module calendar_date_day_adder_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic                         i_op,
    input  logic [cdda_pkg::YEAR_W-1:0]  i_load_year,
    input  logic [cdda_pkg::MONTH_W-1:0] i_load_month,
    input  logic [cdda_pkg::DAY_W-1:0]   i_load_day,
    input  logic [cdda_pkg::COUNT_W-1:0] i_day_count,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic [cdda_pkg::YEAR_W-1:0]  i_cur_year,
    input  logic [cdda_pkg::MONTH_W-1:0] i_cur_month,
    input  logic [cdda_pkg::DAY_W-1:0]   i_cur_day,
    input  logic                         i_year_overflow,
    output int                           o_mismatches,
    output int                           o_pending,
    output int                           o_checked
);
    import cdda_pkg::*;
    import cdda_tb_pkg::*;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic               overflow;
    } t_date_item;

    localparam int unsigned YEAR_LO = 32'(FIRST_YEAR);
    localparam int unsigned YEAR_HI = 32'(LAST_YEAR);
    localparam int unsigned MON_JAN = 32'(JANUARY);
    localparam int unsigned MON_FEB = 32'(FEBRUARY);
    localparam int unsigned MON_DEC = 32'(DECEMBER);
    localparam int unsigned DAY_LO  = 32'(FIRST_DAY);
    localparam int unsigned DAY_HI  = 32'(LAST_DAY);
    localparam int unsigned COMMON_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    t_date_item held_date;
    t_date_item expected_dates [$];
    int         mismatch_count = 0;
    int         checked_count  = 0;

    function automatic bit leap_year(input int unsigned year);
        return ((year % 4) == 0 && (year % 100) != 0) || ((year % 400) == 0);
    endfunction

    function automatic int unsigned month_days(input int unsigned year, input int unsigned month);
        if (month == MON_FEB) begin
            return leap_year(year) ? 29 : 28;
        end
        return COMMON_DAYS[month - 1];
    endfunction

    // Date after one item; the walk crosses one month boundary per pass
    function automatic t_date_item next_date(input t_date_item cur, input t_date_op op,
                                             input int unsigned ld_year,
                                             input int unsigned ld_month,
                                             input int unsigned ld_day,
                                             input int unsigned count);
        t_date_item  nxt;
        int unsigned year;
        int unsigned month;
        int unsigned day;
        int unsigned left;
        int unsigned len;
        year         = cur.year;
        month        = cur.month;
        day          = cur.day;
        left         = count;
        nxt.overflow = 1'b0;
        if (op == OP_LOAD) begin
            year  = (ld_year < YEAR_LO) ? YEAR_LO : (ld_year > YEAR_HI) ? YEAR_HI : ld_year;
            month = (ld_month < MON_JAN) ? MON_JAN : (ld_month > MON_DEC) ? MON_DEC : ld_month;
            len   = month_days(year, month);
            day   = (ld_day < DAY_LO) ? DAY_LO : (ld_day > len) ? len : ld_day;
        end else begin
            len = month_days(year, month);
            while (!nxt.overflow && day + left > len) begin
                left = left - (len - day + 1);
                day  = DAY_LO;
                if (month == MON_DEC) begin
                    if (year == YEAR_HI) begin
                        // saturate at the last day of the last year
                        day          = DAY_HI;
                        left         = 0;
                        nxt.overflow = 1'b1;
                    end else begin
                        year  = year + 1;
                        month = MON_JAN;
                    end
                end else begin
                    month = month + 1;
                end
                len = month_days(year, month);
            end
            day = day + left;
        end
        nxt.year  = YEAR_W'(year);
        nxt.month = MONTH_W'(month);
        nxt.day   = DAY_W'(day);
        return nxt;
    endfunction

    always @(posedge i_clk) begin
        t_date_item got;
        t_date_item want;
        if (!i_rst_n) begin
            held_date = '{FIRST_YEAR, JANUARY, FIRST_DAY, 1'b0};
            expected_dates.delete();
        end else begin
            // retire results first, so a result can never match the item taken this edge
            if (i_out_valid && !i_out_stall) begin
                got = '{i_cur_year, i_cur_month, i_cur_day, i_year_overflow};
                if (expected_dates.size() == 0) begin
                    $display("%0t: unexpected result %0d-%0d-%0d overflow %0b", $time,
                             got.year, got.month, got.day, got.overflow);
                    mismatch_count++;
                end else begin
                    want = expected_dates.pop_front();
                    checked_count++;
                    if (got !== want) begin
                        $display("%0t: expected %0d-%0d-%0d overflow %0b, got %0d-%0d-%0d overflow %0b",
                                 $time, want.year, want.month, want.day, want.overflow,
                                 got.year, got.month, got.day, got.overflow);
                        mismatch_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                held_date = next_date(held_date, t_date_op'(i_op), 32'(i_load_year),
                                      32'(i_load_month), 32'(i_load_day), 32'(i_day_count));
                expected_dates.push_back(held_date);
            end
        end
        o_pending    <= expected_dates.size();
        o_mismatches <= mismatch_count;
        o_checked    <= checked_count;
    end

endmodule

// File: tb/calendar_date_day_adder_unit_tb.sv
`timescale 1ns / 1ps
// Bench top for the calendar date day adder: drives load and add items in bursts, stalls the
// result side on a pattern of its own and gives the verdict.
// Depends on cdda_pkg, cdda_tb_pkg and calendar_date_day_adder_checker.
module calendar_date_day_adder_unit_tb;
    import cdda_pkg::*;
    import cdda_tb_pkg::*;

    // A count of 65535 walks about 2200 months, one per cycle. Even if every item were that
    // slow, with the longest gaps and stalls on top, the run would stay well inside this.
    localparam int unsigned CYCLE_LIMIT  = 5_000_000;
    // A load of year 9999 takes the most subtraction steps of any load; leave a margin once all has drained.
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned RANDOM_ITEMS = 250;

    typedef enum int unsigned {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HALF,
        STALL_HEAVY
    } t_stall_mode;

    // Every block input starts at a known value
    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_in_valid   = 1'b0;
    logic                 i_op         = OP_LOAD;
    logic [YEAR_W-1:0]    i_load_year  = '0;
    logic [MONTH_W-1:0]   i_load_month = '0;
    logic [DAY_W-1:0]     i_load_day   = '0;
    logic [COUNT_W-1:0]   i_day_count  = '0;
    logic                 i_out_stall  = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [YEAR_W-1:0]    o_cur_year;
    logic [MONTH_W-1:0]   o_cur_month;
    logic [DAY_W-1:0]     o_cur_day;
    logic                 o_year_overflow;

    int                   mismatch_total;
    int                   results_pending;
    int                   dates_compared;
    int                   load_items  = 0;
    int                   add_items   = 0;
    int                   burst_left  = 0;
    int unsigned          cycle_count = 0;

    calendar_date_day_adder_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_load_year     (i_load_year),
        .i_load_month    (i_load_month),
        .i_load_day      (i_load_day),
        .i_day_count     (i_day_count),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_cur_year      (o_cur_year),
        .o_cur_month     (o_cur_month),
        .o_cur_day       (o_cur_day),
        .o_year_overflow (o_year_overflow)
    );

    calendar_date_day_adder_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_load_year     (i_load_year),
        .i_load_month    (i_load_month),
        .i_load_day      (i_load_day),
        .i_day_count     (i_day_count),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_cur_year      (o_cur_year),
        .i_cur_month     (o_cur_month),
        .i_cur_day       (o_cur_day),
        .i_year_overflow (o_year_overflow),
        .o_mismatches    (mismatch_total),
        .o_pending       (results_pending),
        .o_checked       (dates_compared)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Present one item and hold it until the block takes it. Valid stays high into the next
    // item unless the current burst has run out, in which case drop it for a random gap.
    task automatic send_item(input t_date_op op, input logic [YEAR_W-1:0] year,
                             input logic [MONTH_W-1:0] month, input logic [DAY_W-1:0] day,
                             input logic [COUNT_W-1:0] count);
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_load_year  <= year;
        i_load_month <= month;
        i_load_day   <= day;
        i_day_count  <= count;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (op == OP_LOAD) begin
            load_items++;
        end else begin
            add_items++;
        end
        if (burst_left == 0) begin
            // mostly short bursts, now and then a long stretch with no idling at all
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end else begin
            burst_left--;
        end
    endtask

    // The count field of a load and the date fields of an add carry noise
    task automatic send_load(input int unsigned year, input int unsigned month,
                             input int unsigned day);
        send_item(OP_LOAD, YEAR_W'(year), MONTH_W'(month), DAY_W'(day), COUNT_W'($urandom()));
    endtask

    task automatic send_add(input int unsigned count);
        send_item(OP_ADD, YEAR_W'($urandom()), MONTH_W'($urandom()), DAY_W'($urandom()),
                  COUNT_W'(count));
    endtask

    // Mostly well-formed loads around awkward dates and adds of modest length, with a share
    // of raw out-of-range loads and a few very long walks
    task automatic send_random_item();
        int unsigned pick;
        int unsigned year;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            case ($urandom_range(0, 4))
                0:       year = $urandom_range(1, 9999);
                1:       year = 400 * $urandom_range(1, 24);
                2:       year = 100 * $urandom_range(1, 99);
                3:       year = 4 * $urandom_range(1, 2499);
                default: year = $urandom_range(9985, 9999);
            endcase
            send_load(year, $urandom_range(1, 12),
                      ($urandom_range(0, 3) == 0) ? $urandom_range(28, 31)
                                                  : $urandom_range(1, 31));
        end else if (pick < 38) begin
            send_load($urandom(), $urandom(), $urandom());
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                send_add($urandom_range(0, 60));
            end else if (pick < 85) begin
                send_add($urandom_range(0, 800));
            end else if (pick < 97) begin
                send_add($urandom_range(0, 5000));
            end else begin
                send_add($urandom());
            end
        end
    endtask

    // Result side: stretches of no stall, light, even and heavy stalling, each of random length
    initial begin
        t_stall_mode mode;
        forever begin
            mode = t_stall_mode'($urandom_range(0, 3));
            repeat ($urandom_range(5, 60)) begin
                @(posedge i_clk);
                case (mode)
                    STALL_NONE:  i_out_stall <= 1'b0;
                    STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HALF:  i_out_stall <= ($urandom_range(0, 1) == 0);
                    default:     i_out_stall <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Watchdog: end the run if it hangs
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        // hold reset low at the start, release it once and never again
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (3) @(posedge i_clk);

        // Directed part: the date straight after reset, clamping of every load field at both
        // ends, the leap rule for plain, century and 400-year cases, year rollover and
        // saturation at the last day of the last year
        send_add(0);
        send_add(65535);
        send_load(0, 0, 0);
        send_load(16383, 15, 31);
        send_add(1);
        send_load(9999, 1, 1);
        send_add(65535);
        send_load(2000, 2, 31);
        send_add(1);
        send_load(1900, 2, 30);
        send_add(1);
        send_load(2024, 2, 29);
        send_add(366);
        send_load(2023, 4, 31);
        send_add(0);
        send_load(2023, 12, 31);
        send_add(1);
        send_load(2100, 2, 28);
        send_add(1);
        send_load(1600, 2, 28);
        send_add(1);
        send_load(1, 1, 1);
        send_add(31);

        repeat (RANDOM_ITEMS) send_random_item();
        i_in_valid <= 1'b0;

        // let the checker's pending count catch up with the last item before trusting it
        @(posedge i_clk);
        while (results_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d load items and %0d day additions, %0d result dates compared",
                 load_items, add_items, dates_compared);
        if (mismatch_total == 0 && results_pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/cdda_pkg.sv
hw/rtl/cdda_step.sv
hw/rtl/calendar_date_day_adder_unit.sv
hw/rtl/cdda_checker.sv
tb/calendar_date_day_adder_checker.sv
tb/calendar_date_day_adder_unit_tb.sv
